// File: hdl/vca_pkg.sv
// shared types, constants and helpers of the voice channel allocator
`default_nettype none
package vca_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int HANDLE_W     = 32;
   localparam int SOUND_W      = 16;
   localparam int FADE_W       = 16;
   localparam int CHAN_OUT_W   = 3;
   localparam int CLASS_W      = 2;
   localparam int KEY_W        = CLASS_W + HANDLE_W;

   typedef enum logic [2:0] {
      REQ_PLAY     = 3'd0,
      REQ_STOP     = 3'd1,
      REQ_PAUSE    = 3'd2,
      REQ_RESUME   = 3'd3,
      REQ_QUERY    = 3'd4,
      REQ_FINISHED = 3'd5
   } req_kind_type;

   typedef enum logic [2:0] {
      CMD_NONE     = 3'd0,
      CMD_PLAY     = 3'd1,
      CMD_FADE_IN  = 3'd2,
      CMD_HALT     = 3'd3,
      CMD_FADE_OUT = 3'd4,
      CMD_PAUSE    = 3'd5,
      CMD_RESUME   = 3'd6
   } mixer_cmd_type;

   typedef enum logic [1:0] {
      SND_STOPPED = 2'd0,
      SND_PLAYING = 2'd1,
      SND_PAUSED  = 2'd2
   } sound_state_type;

   // steal preference: lower class wins, then smaller handle
   typedef enum logic [CLASS_W-1:0] {
      CLS_SAME_SOUND = 2'd0,
      CLS_ONE_SHOT   = 2'd1,
      CLS_LOOPING    = 2'd2
   } steal_class_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_SCAN = 2'd1,
      FSM_EXEC = 2'd2
   } fsm_state_type;

   typedef struct packed {
      logic [2:0]          req_type;
      logic [SOUND_W-1:0]  sound_id;
      logic                loop_request;
      logic [HANDLE_W-1:0] target_handle;
      logic [2:0]          done_channel;
      logic [FADE_W-1:0]   fade_ms;
   } req_data_type;

   typedef struct packed {
      logic [HANDLE_W-1:0]   new_handle;
      logic [CHAN_OUT_W-1:0] chan_index;
      logic [2:0]            mixer_cmd;
      logic                  loop_forever;
      logic [FADE_W-1:0]     fade_out_ms;
      logic                  was_stolen;
      logic                  found;
      logic [1:0]            sound_state;
   } rsp_data_type;

   typedef struct packed {
      logic                valid;
      logic [HANDLE_W-1:0] handle;
      logic [SOUND_W-1:0]  sound;
      logic                looping;
      logic                paused;
   } chan_entry_type;

   typedef struct packed {
      logic            en;
      logic [CH_W-1:0] addr;
      chan_entry_type  entry;
   } tbl_wr_type;

   // channel number masked to the width of chan_index
   function automatic logic [CHAN_OUT_W-1:0] chan_out(input logic [CH_W-1:0] c);
      logic [CH_W+CHAN_OUT_W-1:0] w;
      w = {{CHAN_OUT_W{1'b0}}, c};
      return w[CHAN_OUT_W-1:0];
   endfunction

endpackage
`default_nettype wire

// File: hdl/vca_table.sv
// channel table: valid marks in flops, entry fields with one read and one write port
`default_nettype none
module vca_table import vca_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tbl_wr_type              wr,
   input  wire logic [CH_W-1:0]         rd_addr,
   output chan_entry_type               rd_entry,
   output logic [NUM_CHANNELS-1:0]      valid_vec
);

   logic [NUM_CHANNELS-1:0] valid_ff;
   logic [NUM_CHANNELS-1:0] valid_in;
   logic [HANDLE_W-1:0]     handle_ff  [NUM_CHANNELS];
   logic [SOUND_W-1:0]      sound_ff   [NUM_CHANNELS];
   logic                    looping_ff [NUM_CHANNELS];
   logic                    paused_ff  [NUM_CHANNELS];

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = wr.entry.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload fields need no reset, an invalid entry is never used
   always_ff @(posedge clock) begin
      if (wr.en) begin
         handle_ff[wr.addr]  <= wr.entry.handle;
         sound_ff[wr.addr]   <= wr.entry.sound;
         looping_ff[wr.addr] <= wr.entry.looping;
         paused_ff[wr.addr]  <= wr.entry.paused;
      end
   end

   always_comb begin
      rd_entry.valid   = valid_ff[rd_addr];
      rd_entry.handle  = handle_ff[rd_addr];
      rd_entry.sound   = sound_ff[rd_addr];
      rd_entry.looping = looping_ff[rd_addr];
      rd_entry.paused  = paused_ff[rd_addr];
   end

   assign valid_vec = valid_ff;

endmodule
`default_nettype wire

// File: hdl/vca_cmp.sv
// shared subtract-compare unit for handle lookup and steal ranking
`default_nettype none
module vca_cmp import vca_pkg::*; (
   input  wire logic [KEY_W-1:0] a,
   input  wire logic [KEY_W-1:0] b,
   output logic                  lt,
   output logic                  eq
);

   logic [KEY_W:0] diff;

   assign diff = {1'b0, a} - {1'b0, b};
   assign lt   = diff[KEY_W];
   assign eq   = (diff == '0);

endmodule
`default_nettype wire

// File: hdl/voice_channel_allocator.sv
// voice channel allocator top level: sequencer, channel table and shared compare unit
// play, stop, pause, resume and query scan the whole table before they give their result;
//   finished and unused kinds skip the scan
// a new transaction is accepted only once the last one has left the sequencer; lookups are
//   paced by the scan that walks one channel entry a cycle through the single compare unit
// reset clears the valid marks, the handle counter and the sequencer; entry fields are
//   not reset since an invalid entry is never used
`default_nettype none
module voice_channel_allocator import vca_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_data_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_data_type      rsp_data
);

   // sequencer state
   fsm_state_type state_ff, state_in;
   req_data_type  req_ff, req_in;
   logic [CH_W-1:0] idx_ff, idx_in;

   // scan results
   logic            free_found_ff, free_found_in;
   logic [CH_W-1:0] free_ch_ff, free_ch_in;
   logic            best_found_ff, best_found_in;
   logic [KEY_W-1:0] best_key_ff, best_key_in;
   logic [CH_W-1:0] best_ch_ff, best_ch_in;
   logic            match_found_ff, match_found_in;
   logic [CH_W-1:0] match_ch_ff, match_ch_in;
   logic [SOUND_W-1:0] match_sound_ff, match_sound_in;
   logic            match_loop_ff, match_loop_in;
   logic            match_paused_ff, match_paused_in;

   logic [HANDLE_W-1:0] handle_cnt_ff, handle_cnt_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_ff, rsp_in;

   // table and compare unit hookup
   tbl_wr_type              tbl_wr;
   chan_entry_type          rd_entry;
   logic [NUM_CHANNELS-1:0] valid_vec;
   logic [KEY_W-1:0]        cmp_a, cmp_b;
   logic                    cmp_lt, cmp_eq;

   // helpers
   logic                 is_play;
   logic                 slot_free;
   logic                 last_idx;
   steal_class_type      cls;
   logic [HANDLE_W-1:0]  hc_inc;
   logic [CH_W+2:0]      dc_wide;
   logic [CH_W-1:0]      dc_idx;
   logic                 dc_in_range;
   logic [CH_W-1:0]      play_ch;

   vca_table u_table (
      .clock     (clock),
      .reset     (reset),
      .wr        (tbl_wr),
      .rd_addr   (idx_ff),
      .rd_entry  (rd_entry),
      .valid_vec (valid_vec)
   );

   vca_cmp u_cmp (
      .a  (cmp_a),
      .b  (cmp_b),
      .lt (cmp_lt),
      .eq (cmp_eq)
   );

   assign req_stall = (state_ff != FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign is_play   = (req_ff.req_type == REQ_PLAY);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign last_idx  = (idx_ff == CH_W'(NUM_CHANNELS - 1));

   // steal ranking key: same sound first, then one-shot, then anything
   always_comb begin
      if (rd_entry.sound == req_ff.sound_id) begin
         cls = CLS_SAME_SOUND;
      end else if (!rd_entry.looping) begin
         cls = CLS_ONE_SHOT;
      end else begin
         cls = CLS_LOOPING;
      end
   end

   // play ranks entries against the best so far, other kinds match the handle
   always_comb begin
      if (is_play) begin
         cmp_a = {cls, rd_entry.handle};
         cmp_b = best_key_ff;
      end else begin
         cmp_a = {{CLASS_W{1'b0}}, rd_entry.handle};
         cmp_b = {{CLASS_W{1'b0}}, req_ff.target_handle};
      end
   end

   // handle counter wraps past zero
   always_comb begin
      hc_inc = handle_cnt_ff + HANDLE_W'(1);
      if (hc_inc == '0) begin
         hc_inc = HANDLE_W'(1);
      end
   end

   assign dc_wide     = (CH_W + 3)'(req_ff.done_channel);
   assign dc_idx      = dc_wide[CH_W-1:0];
   assign dc_in_range = ({29'b0, req_ff.done_channel} < 32'(NUM_CHANNELS));
   assign play_ch     = free_found_ff ? free_ch_ff : best_ch_ff;

   always_comb begin
      state_in        = state_ff;
      req_in          = req_ff;
      idx_in          = idx_ff;
      free_found_in   = free_found_ff;
      free_ch_in      = free_ch_ff;
      best_found_in   = best_found_ff;
      best_key_in     = best_key_ff;
      best_ch_in      = best_ch_ff;
      match_found_in  = match_found_ff;
      match_ch_in     = match_ch_ff;
      match_sound_in  = match_sound_ff;
      match_loop_in   = match_loop_ff;
      match_paused_in = match_paused_ff;
      handle_cnt_in   = handle_cnt_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_in          = rsp_ff;
      tbl_wr          = '0;

      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               req_in         = req_data;
               idx_in         = '0;
               free_found_in  = 1'b0;
               best_found_in  = 1'b0;
               match_found_in = 1'b0;
               if (req_data.req_type <= REQ_QUERY) begin
                  state_in = FSM_SCAN;
               end else begin
                  state_in = FSM_EXEC;
               end
            end
         end

         // one channel entry per cycle through the compare unit
         FSM_SCAN: begin
            if (is_play) begin
               if (!rd_entry.valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_ch_in    = idx_ff;
               end
               if (rd_entry.valid && (!best_found_ff || cmp_lt)) begin
                  best_found_in = 1'b1;
                  best_key_in   = cmp_a;
                  best_ch_in    = idx_ff;
               end
            end else if (rd_entry.valid && cmp_eq && (req_ff.target_handle != '0)
                         && !match_found_ff) begin
               match_found_in  = 1'b1;
               match_ch_in     = idx_ff;
               match_sound_in  = rd_entry.sound;
               match_loop_in   = rd_entry.looping;
               match_paused_in = rd_entry.paused;
            end
            if (last_idx) begin
               state_in = FSM_EXEC;
            end else begin
               idx_in = idx_ff + CH_W'(1);
            end
         end

         // build the result and update the table once the output register is free
         FSM_EXEC: begin
            if (slot_free) begin
               state_in     = FSM_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               unique case (req_kind_type'(req_ff.req_type))
                  REQ_PLAY: begin
                     handle_cnt_in       = hc_inc;
                     tbl_wr.en           = 1'b1;
                     tbl_wr.addr         = play_ch;
                     tbl_wr.entry.valid  = 1'b1;
                     tbl_wr.entry.handle = hc_inc;
                     tbl_wr.entry.sound  = req_ff.sound_id;
                     tbl_wr.entry.looping = req_ff.loop_request;
                     tbl_wr.entry.paused = 1'b0;
                     rsp_in.new_handle   = hc_inc;
                     rsp_in.chan_index   = chan_out(play_ch);
                     rsp_in.mixer_cmd    = (req_ff.fade_ms != '0) ? CMD_FADE_IN : CMD_PLAY;
                     rsp_in.loop_forever = req_ff.loop_request;
                     rsp_in.fade_out_ms  = req_ff.fade_ms;
                     rsp_in.was_stolen   = !free_found_ff;
                     rsp_in.sound_state  = SND_PLAYING;
                  end
                  REQ_STOP, REQ_PAUSE, REQ_RESUME, REQ_QUERY: begin
                     if (match_found_ff) begin
                        rsp_in.chan_index    = chan_out(match_ch_ff);
                        rsp_in.found         = 1'b1;
                        tbl_wr.addr          = match_ch_ff;
                        tbl_wr.entry.valid   = 1'b1;
                        tbl_wr.entry.handle  = req_ff.target_handle;
                        tbl_wr.entry.sound   = match_sound_ff;
                        tbl_wr.entry.looping = match_loop_ff;
                        tbl_wr.entry.paused  = match_paused_ff;
                        rsp_in.sound_state   = match_paused_ff ? SND_PAUSED : SND_PLAYING;
                        if (req_ff.req_type == REQ_STOP) begin
                           if (req_ff.fade_ms != '0) begin
                              // fade keeps the entry until the mixer reports it done
                              rsp_in.mixer_cmd   = CMD_FADE_OUT;
                              rsp_in.fade_out_ms = req_ff.fade_ms;
                           end else begin
                              rsp_in.mixer_cmd   = CMD_HALT;
                              rsp_in.sound_state = SND_STOPPED;
                              tbl_wr.en          = 1'b1;
                              tbl_wr.entry       = '0;
                           end
                        end else if (req_ff.req_type == REQ_PAUSE) begin
                           rsp_in.sound_state = SND_PAUSED;
                           if (!match_paused_ff) begin
                              rsp_in.mixer_cmd    = CMD_PAUSE;
                              tbl_wr.en           = 1'b1;
                              tbl_wr.entry.paused = 1'b1;
                           end
                        end else if (req_ff.req_type == REQ_RESUME) begin
                           rsp_in.sound_state = SND_PLAYING;
                           if (match_paused_ff) begin
                              rsp_in.mixer_cmd    = CMD_RESUME;
                              tbl_wr.en           = 1'b1;
                              tbl_wr.entry.paused = 1'b0;
                           end
                        end
                     end
                  end
                  REQ_FINISHED: begin
                     rsp_in.chan_index = req_ff.done_channel;
                     if (dc_in_range && valid_vec[dc_idx]) begin
                        rsp_in.found = 1'b1;
                        tbl_wr.en    = 1'b1;
                        tbl_wr.addr  = dc_idx;
                        tbl_wr.entry = '0;
                     end
                  end
                  default: begin
                     // unused request kinds answer with all zeros
                     rsp_in = '0;
                  end
               endcase
            end
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= FSM_IDLE;
         handle_cnt_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         handle_cnt_ff  <= handle_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff          <= req_in;
      idx_ff          <= idx_in;
      free_found_ff   <= free_found_in;
      free_ch_ff      <= free_ch_in;
      best_found_ff   <= best_found_in;
      best_key_ff     <= best_key_in;
      best_ch_ff      <= best_ch_in;
      match_found_ff  <= match_found_in;
      match_ch_ff     <= match_ch_in;
      match_sound_ff  <= match_sound_in;
      match_loop_ff   <= match_loop_in;
      match_paused_ff <= match_paused_in;
      rsp_ff          <= rsp_in;
   end

   // an accepted transaction always leaves the idle state
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != FSM_IDLE))
      else $error("sequencer stayed idle after accepting a request");

   // once a handle was given out, the counter never returns to zero
   assert property (@(posedge clock) disable iff (reset)
      (handle_cnt_ff != '0) |=> (handle_cnt_ff != '0))
      else $error("handle counter wrapped onto zero");

   // play results always carry a live handle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_data.mixer_cmd == CMD_PLAY) || (rsp_data.mixer_cmd == CMD_FADE_IN)))
      |-> (rsp_data.new_handle != '0))
      else $error("play result without a handle");

   // the free channel picked by the scan is really empty when play executes
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == FSM_EXEC) && is_play && free_found_ff) |-> !valid_vec[free_ch_ff])
      else $error("play picked an occupied channel as free");

endmodule
`default_nettype wire

// File: tb/voice_channel_allocator_tb.sv
// self-checking testbench of the voice channel allocator
`timescale 1ns / 100ps
module voice_channel_allocator_tb;
   import vca_pkg::*;

   // request kinds that the block must ignore
   localparam logic [2:0] REQ_SPARE_A = 3'd6;
   localparam logic [2:0] REQ_SPARE_B = 3'd7;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 800;

   // order in which a full table gives up a voice
   typedef enum {PICK_SAME_SOUND, PICK_ONE_SHOT, PICK_ANY} victim_rule_type;

   // channel table mirror plus the queue of mixer responses still owed by the block
   class voice_table_scoreboard;
      bit                  live       [NUM_CHANNELS];
      logic [HANDLE_W-1:0] handle_tbl [NUM_CHANNELS];
      logic [SOUND_W-1:0]  sound_tbl  [NUM_CHANNELS];
      logic                looping    [NUM_CHANNELS];
      logic                paused     [NUM_CHANNELS];
      logic [HANDLE_W-1:0] handle_count;
      rsp_data_type        owed_responses[$];
      int                  errors;

      function new();
         int i;
         for (i = 0; i < NUM_CHANNELS; i++) begin
            live[i]       = 1'b0;
            handle_tbl[i] = '0;
            sound_tbl[i]  = '0;
            looping[i]    = 1'b0;
            paused[i]     = 1'b0;
         end
         handle_count = '0;
         errors       = 0;
      endfunction

      // live entry with the smallest handle that the rule admits, lowest channel on ties
      function int oldest_entry(victim_rule_type rule, logic [SOUND_W-1:0] snd);
         int best;
         int i;
         best = -1;
         for (i = 0; i < NUM_CHANNELS; i++) begin
            if (live[i] && !(rule == PICK_SAME_SOUND && sound_tbl[i] != snd)
                && !(rule == PICK_ONE_SHOT && looping[i])) begin
               if (best < 0 || handle_tbl[i] < handle_tbl[best])
                  best = i;
            end
         end
         return best;
      endfunction

      function void clear_channel(int ch);
         live[ch]       = 1'b0;
         handle_tbl[ch] = '0;
         sound_tbl[ch]  = '0;
         looping[ch]    = 1'b0;
         paused[ch]     = 1'b0;
      endfunction

      // random live channel, -1 when the table is empty
      function int pick_live_channel();
         int ch_list[$];
         int i;
         for (i = 0; i < NUM_CHANNELS; i++)
            if (live[i])
               ch_list.push_back(i);
         if (ch_list.size() == 0)
            return -1;
         return ch_list[$urandom_range(0, ch_list.size() - 1)];
      endfunction

      // updates the table for one request and returns the mixer response it causes
      function rsp_data_type mixer_response_for(req_data_type r);
         rsp_data_type o;
         int           ch;
         int           i;
         bit           stolen;
         o      = '0;
         ch     = -1;
         stolen = 1'b0;
         case (r.req_type)
            REQ_PLAY: begin
               for (i = NUM_CHANNELS - 1; i >= 0; i--)
                  if (!live[i])
                     ch = i;
               if (ch < 0) begin
                  stolen = 1'b1;
                  ch = oldest_entry(PICK_SAME_SOUND, r.sound_id);
                  if (ch < 0)
                     ch = oldest_entry(PICK_ONE_SHOT, r.sound_id);
                  if (ch < 0)
                     ch = oldest_entry(PICK_ANY, r.sound_id);
               end
               handle_count = handle_count + 1;
               if (handle_count == '0)
                  handle_count = 1;
               live[ch]       = 1'b1;
               handle_tbl[ch] = handle_count;
               sound_tbl[ch]  = r.sound_id;
               looping[ch]    = r.loop_request;
               paused[ch]     = 1'b0;
               o.new_handle   = handle_count;
               o.chan_index   = CHAN_OUT_W'(ch);
               o.mixer_cmd    = (r.fade_ms != '0) ? CMD_FADE_IN : CMD_PLAY;
               o.loop_forever = r.loop_request;
               o.fade_out_ms  = r.fade_ms;
               o.was_stolen   = stolen;
               o.sound_state  = SND_PLAYING;
            end
            REQ_STOP, REQ_PAUSE, REQ_RESUME, REQ_QUERY: begin
               // handle 0 never matches; duplicates resolve to the lowest channel
               if (r.target_handle != '0)
                  for (i = NUM_CHANNELS - 1; i >= 0; i--)
                     if (live[i] && handle_tbl[i] == r.target_handle)
                        ch = i;
               if (ch >= 0) begin
                  o.chan_index = CHAN_OUT_W'(ch);
                  o.found      = 1'b1;
                  case (r.req_type)
                     REQ_STOP: begin
                        if (r.fade_ms != '0) begin
                           o.mixer_cmd   = CMD_FADE_OUT;
                           o.fade_out_ms = r.fade_ms;
                           o.sound_state = paused[ch] ? SND_PAUSED : SND_PLAYING;
                        end else begin
                           o.mixer_cmd   = CMD_HALT;
                           o.sound_state = SND_STOPPED;
                           clear_channel(ch);
                        end
                     end
                     REQ_PAUSE: begin
                        if (!paused[ch]) begin
                           paused[ch]  = 1'b1;
                           o.mixer_cmd = CMD_PAUSE;
                        end
                        o.sound_state = SND_PAUSED;
                     end
                     REQ_RESUME: begin
                        if (paused[ch]) begin
                           paused[ch]  = 1'b0;
                           o.mixer_cmd = CMD_RESUME;
                        end
                        o.sound_state = SND_PLAYING;
                     end
                     default: begin
                        o.sound_state = paused[ch] ? SND_PAUSED : SND_PLAYING;
                     end
                  endcase
               end
            end
            REQ_FINISHED: begin
               o.chan_index = r.done_channel;
               if (r.done_channel < NUM_CHANNELS && live[r.done_channel]) begin
                  clear_channel(r.done_channel);
                  o.found = 1'b1;
               end
            end
            default: begin
            end
         endcase
         return o;
      endfunction

      function void note_accepted_request(req_data_type r);
         owed_responses.push_back(mixer_response_for(r));
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("mismatch on %s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_mixer_response(rsp_data_type got);
         rsp_data_type want;
         if (owed_responses.size() == 0) begin
            $error("response with no request outstanding: %h", got);
            errors++;
            return;
         end
         want = owed_responses.pop_front();
         compare_field("new_handle", want.new_handle, got.new_handle);
         compare_field("chan_index", 32'(want.chan_index), 32'(got.chan_index));
         compare_field("mixer_cmd", 32'(want.mixer_cmd), 32'(got.mixer_cmd));
         compare_field("loop_forever", 32'(want.loop_forever), 32'(got.loop_forever));
         compare_field("fade_out_ms", 32'(want.fade_out_ms), 32'(got.fade_out_ms));
         compare_field("was_stolen", 32'(want.was_stolen), 32'(got.was_stolen));
         compare_field("found", 32'(want.found), 32'(got.found));
         compare_field("sound_state", 32'(want.sound_state), 32'(got.sound_state));
      endfunction
   endclass

   // every input of the block starts at a known value
   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   req_data_type req_data  = '0;
   logic         rsp_stall = 1'b0;
   logic         req_stall;
   logic         rsp_valid;
   rsp_data_type rsp_data;

   voice_table_scoreboard sb;

   int          stall_left  = 0;
   int          run_left    = 0;
   int unsigned cycle_count = 0;

   voice_channel_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side: check each accepted transaction, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_mixer_response(rsp_data);
      if (stall_left == 0 && run_left == 0) begin
         case ($urandom_range(0, 9))
            0:       run_left = $urandom_range(150, 300);   // long stretch with no stall
            1, 2:    run_left = $urandom_range(9, 40);
            default: run_left = $urandom_range(1, 8);
         endcase
         case ($urandom_range(0, 19))
            0, 1, 2:             stall_left = $urandom_range(15, 50);
            3, 4, 5, 6, 7, 8:    stall_left = 0;
            default:             stall_left = $urandom_range(1, 3);
         endcase
      end
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         run_left = run_left - 1;
         rsp_stall <= 1'b0;
      end
   end

   // sender idle time: mostly none or short, now and then long
   function automatic int sender_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50)
         return 0;
      if (p < 92)
         return $urandom_range(1, 4);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_data_type make_req(logic [2:0] kind, logic [SOUND_W-1:0] snd,
                                             logic lp, logic [HANDLE_W-1:0] hnd,
                                             logic [2:0] dchan, logic [FADE_W-1:0] fade);
      req_data_type r;
      r.req_type      = kind;
      r.sound_id      = snd;
      r.loop_request  = lp;
      r.target_handle = hnd;
      r.done_channel  = dchan;
      r.fade_ms       = fade;
      return r;
   endfunction

   // random request: all fields random, then shaped so most lookups hit live handles
   function automatic req_data_type random_request(int play_pct);
      req_data_type r;
      int           pick;
      int           ch;
      r = make_req(3'($urandom), SOUND_W'($urandom), 1'($urandom), $urandom,
                   3'($urandom), FADE_W'($urandom));
      if ($urandom_range(0, 99) < play_pct) begin
         r.req_type = REQ_PLAY;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 25)
            r.req_type = REQ_STOP;
         else if (pick < 43)
            r.req_type = REQ_PAUSE;
         else if (pick < 61)
            r.req_type = REQ_RESUME;
         else if (pick < 75)
            r.req_type = REQ_QUERY;
         else if (pick < 96)
            r.req_type = REQ_FINISHED;
         else
            r.req_type = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
      end
      // a small pool of sound ids makes same-sound steals common
      if ($urandom_range(0, 9) < 6)
         r.sound_id = SOUND_W'($urandom_range(1, 4));
      pick = $urandom_range(0, 9);
      if (pick < 5)
         r.fade_ms = '0;
      else if (pick == 5)
         r.fade_ms = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
      ch = sb.pick_live_channel();
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
         if (ch >= 0)
            r.target_handle = sb.handle_tbl[ch];
      end else if (pick < 17) begin
         // stale or still live, whichever it happens to be
         r.target_handle = $urandom_range(1, sb.handle_count + 1);
      end else if (pick == 17) begin
         r.target_handle = '0;
      end
      if (ch >= 0 && $urandom_range(0, 9) < 7)
         r.done_channel = 3'(ch);
      return r;
   endfunction

   // one transaction; valid stays high across back-to-back items
   task automatic issue_request(input req_data_type d, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_accepted_request(d);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.owed_responses.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int n;
      int play_pct;
      bit quiet;
      sb = new();
      play_pct = 45;
      quiet    = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // lookups on an empty table, finished report for an empty channel, unused kinds
      issue_request(make_req(REQ_QUERY, 0, 0, 32'h0, 0, 0), sender_gap());
      issue_request(make_req(REQ_STOP, 0, 0, 32'hFFFF_FFFF, 0, 16'hFFFF), sender_gap());
      issue_request(make_req(REQ_FINISHED, 0, 0, 0, 3'd7, 0), sender_gap());
      issue_request(make_req(REQ_SPARE_A, '1, 1, '1, '1, '1), sender_gap());
      issue_request(make_req(REQ_SPARE_B, '1, 1, '1, '1, '1), sender_gap());

      // fill every channel: handles 1 to 8 on channels 0 to 7
      issue_request(make_req(REQ_PLAY, 16'h0000, 1, 0, 0, 0), sender_gap());
      issue_request(make_req(REQ_PLAY, 16'hFFFF, 0, 0, 0, 16'hFFFF), sender_gap());
      issue_request(make_req(REQ_PLAY, 16'd5, 1, 0, 0, 0), sender_gap());
      issue_request(make_req(REQ_PLAY, 16'd5, 0, 0, 0, 16'd1), sender_gap());
      repeat (4)
         issue_request(make_req(REQ_PLAY, 16'd7, 1, 0, 0, 0), sender_gap());

      // steal by same sound, then the one-shots, then the oldest of all looping voices
      issue_request(make_req(REQ_PLAY, 16'd5, 1, 0, 0, 0), sender_gap());
      issue_request(make_req(REQ_PLAY, 16'h1234, 1, 0, 0, 16'h00FF), sender_gap());
      issue_request(make_req(REQ_PLAY, 16'h1235, 1, 0, 0, 0), sender_gap());
      issue_request(make_req(REQ_PLAY, 16'h4321, 0, 0, 0, 0), sender_gap());

      // pause twice, query while paused, resume twice
      issue_request(make_req(REQ_PAUSE, 0, 0, 32'd5, 0, 0), sender_gap());
      issue_request(make_req(REQ_PAUSE, 0, 0, 32'd5, 0, 0), sender_gap());
      issue_request(make_req(REQ_QUERY, 0, 0, 32'd5, 0, 0), sender_gap());
      issue_request(make_req(REQ_RESUME, 0, 0, 32'd5, 0, 0), sender_gap());
      issue_request(make_req(REQ_RESUME, 0, 0, 32'd5, 0, 0), sender_gap());

      // fade-out of a paused voice keeps the entry; a plain stop halts and frees another voice
      issue_request(make_req(REQ_PAUSE, 0, 0, 32'd7, 0, 0), sender_gap());
      issue_request(make_req(REQ_STOP, 0, 0, 32'd7, 0, 16'd1), sender_gap());
      issue_request(make_req(REQ_STOP, 0, 0, 32'd6, 0, 0), sender_gap());
      issue_request(make_req(REQ_FINISHED, 0, 0, 0, 3'd6, 0), sender_gap());
      issue_request(make_req(REQ_QUERY, 0, 0, 32'd6, 0, 0), sender_gap());
      issue_request(make_req(REQ_PLAY, 16'd9, 0, 0, 0, 0), sender_gap());

      // let the block run dry before the random part
      wait_drained();

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            // pick at random between filling the table and draining it
            play_pct = ($urandom_range(0, 2) == 0) ? 15 : 45;
            quiet    = ($urandom_range(0, 3) == 0);
         end
         if (n == RANDOM_ITEMS / 2)
            wait_drained();
         issue_request(random_request(play_pct), quiet ? 0 : sender_gap());
      end

      wait_drained();
      repeat (2 * NUM_CHANNELS + 8) @(posedge clock);
      if (sb.errors == 0 && sb.owed_responses.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: sim.f
hdl/vca_pkg.sv
hdl/vca_table.sv
hdl/vca_cmp.sv
hdl/voice_channel_allocator.sv
tb/voice_channel_allocator_tb.sv
